>>> hw/rtl/vref_pkg.sv
// Constants, word types and fixed-point helpers for the vector refraction pipeline.
`timescale 1ns / 1ps
package vref_pkg;
	localparam int FRAC_BITS = 14;
	localparam int DW        = 16;
	localparam int SQW       = 2 * DW - 1;
	localparam int SSW       = 2 * DW;
	localparam int RTW       = 24;
	localparam int RAW       = 2 * RTW;
	localparam int RAW1      = RAW + 1;
	localparam int QW        = FRAC_BITS + 2;
	localparam int UW        = FRAC_BITS + 3;
	localparam int DVW       = RTW + QW + 1;
	localparam int CW        = 19;
	localparam int UNW       = UW + DW;
	localparam int EUW       = UW + DW + 1;
	localparam int EEW       = 2 * DW;
	localparam int CCW       = 2 * CW;
	localparam int CNW       = CW + DW;
	localparam int ECPW      = CW + DW + 1;
	localparam int E2W       = 34 - FRAC_BITS;
	localparam int OMW       = ((37 - FRAC_BITS) > (FRAC_BITS + 1) ?
		(37 - FRAC_BITS) : (FRAC_BITS + 1)) + 1;
	localparam int EKW       = OMW + E2W;
	localparam int EURW      = UW + 18 - FRAC_BITS;
	localparam int CNRW      = CW + 18 - FRAC_BITS;
	localparam int ECW       = CW + 18 - FRAC_BITS;
	localparam int KCW       = 43;
	localparam int SW        = (KCW + FRAC_BITS + 1) / 2;
	localparam int RBW       = 2 * SW;
	localparam int RBW1      = RBW + 1;
	localparam int GW        = (ECW > SW + 1 ? ECW : SW + 1) + 1;
	localparam int GNW       = GW + DW;
	localparam int FW        = GW + 20 - FRAC_BITS;
	localparam int NST       = RTW + QW + SW + 13;

	localparam logic signed [63:0]   ONE     = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0]   HALF    = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [63:0]   KMAX    = 64'sd1 <<< (KCW - 1);
	localparam logic signed [FW-1:0] OUT_MAX = FW'(32767);
	localparam logic signed [FW-1:0] OUT_MIN = FW'(-32768);

	typedef struct packed {
		logic signed [DW-1:0] dir_x;
		logic signed [DW-1:0] dir_y;
		logic signed [DW-1:0] dir_z;
		logic signed [DW-1:0] norm_x;
		logic signed [DW-1:0] norm_y;
		logic signed [DW-1:0] norm_z;
		logic [DW-1:0]        eta;
	} vref_in_t;

	typedef struct packed {
		logic signed [DW-1:0] out_x;
		logic signed [DW-1:0] out_y;
		logic signed [DW-1:0] out_z;
		logic                 total_reflect;
	} vref_out_t;

	function automatic logic signed [63:0] rnd(input logic signed [63:0] v);
		logic signed [63:0] adj;
		adj = $signed({63'd0, v[63]});
		return (v + HALF - adj) >>> FRAC_BITS;
	endfunction

	function automatic logic signed [DW-1:0] sat16(input logic signed [FW-1:0] v);
		logic signed [FW-1:0] r;
		r = v;
		if (v > OUT_MAX) begin
			r = OUT_MAX;
		end else if (v < OUT_MIN) begin
			r = OUT_MIN;
		end
		return DW'(r);
	endfunction
endpackage

>>> hw/rtl/vector_refraction.sv
// Pipelined vector refraction with total internal reflection fallback.
//
// Usage:
//   ray channel (ray_valid / ray_stall / ray) takes one word per cycle when
//   not stalled: incident direction, Q1.14 unit normal, Q2.14 index ratio.
//   res channel (res_valid / res_stall / res) returns one word per input word,
//   in order: the Q1.14 saturated result direction and the total_reflect flag.
// Depth: the length square root (one root bit per stage), the normalizing
//   divider (one quotient bit per stage, three lanes) and the square root
//   of k (one bit per stage) make up most of the pipeline; the rest are
//   multiply, round, sign, add and select stages.
// Throughput: one word per cycle when not stalled; every stage advances together.
// Stall: while res_valid is high and res_stall is high the whole pipeline
//   holds and ray_stall is raised; nothing is lost or repeated. Empty slots
//   never block: with res_valid low the pipeline advances regardless.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
//   The block accepts words in the first cycle after reset.
// A zero direction gives a zero result with total_reflect low.
`timescale 1ns / 1ps
module vector_refraction
	import vref_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ray_valid,
	output logic      ray_stall,
	input  vref_in_t  ray,
	output logic      res_valid,
	input  logic      res_stall,
	output vref_out_t res
);

	typedef struct packed {
		logic [2:0][DW-1:0] d;
		logic [2:0][DW-1:0] n;
		logic [DW-1:0]      eta;
		logic               zero;
	} front_t;

	typedef struct packed {
		logic [2:0]         sgn;
		logic [2:0][DW-1:0] n;
		logic [DW-1:0]      eta;
		logic               zero;
	} mid_t;

	typedef struct packed {
		logic [2:0][UW-1:0]   u;
		logic [2:0][EURW-1:0] eur;
		logic [2:0][CNRW-1:0] cnr;
		logic [ECW-1:0]       ecr;
		logic [2:0][DW-1:0]   n;
		logic                 tir;
		logic                 zero;
	} fin_t;

	logic           en;
	logic [NST-1:0] vld_s;

	assign en        = ~vld_s[NST-1] | ~res_stall;
	assign ray_stall = ~en;
	assign res_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], ray_valid};
		end
	end

	// squares
	logic signed [DW-1:0]  d_in [3];
	logic signed [SSW-1:0] sq_in [3];
	logic [SQW-1:0]        sq_s1 [3];
	front_t                fr_s1;

	always_comb begin
		d_in[0] = ray.dir_x;
		d_in[1] = ray.dir_y;
		d_in[2] = ray.dir_z;
		for (int i = 0; i < 3; i++) begin
			sq_in[i] = SSW'(d_in[i]) * SSW'(d_in[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= SQW'(sq_in[i]);
			end
			fr_s1.d    <= {ray.dir_z, ray.dir_y, ray.dir_x};
			fr_s1.n    <= {ray.norm_z, ray.norm_y, ray.norm_x};
			fr_s1.eta  <= ray.eta;
			fr_s1.zero <= 1'b0;
		end
	end

	// length square root
	logic [SSW-1:0] ss;
	front_t         sqa_front;
	logic [RAW-1:0] sqa_rem_s2 [RTW+1];
	logic [RTW-1:0] sqa_root_s2 [RTW+1];
	front_t         sqa_c_s2 [RTW+1];
	logic [RAW:0]   sqa_trial [RTW];
	logic           sqa_take [RTW];
	logic [RAW-1:0] sqa_rem_nx [RTW];
	logic [RTW-1:0] sqa_root_nx [RTW];

	always_comb begin
		ss             = SSW'(sq_s1[0]) + SSW'(sq_s1[1]) + SSW'(sq_s1[2]);
		sqa_front      = fr_s1;
		sqa_front.zero = (ss == '0);
		for (int j = 0; j < RTW; j++) begin
			sqa_trial[j]   = (RAW1'(sqa_root_s2[j]) << (RTW - j))
				+ (RAW1'(1) << (2 * (RTW - 1 - j)));
			sqa_take[j]    = RAW1'(sqa_rem_s2[j]) >= sqa_trial[j];
			sqa_rem_nx[j]  = sqa_take[j] ?
				RAW'(RAW1'(sqa_rem_s2[j]) - sqa_trial[j]) : sqa_rem_s2[j];
			sqa_root_nx[j] = sqa_take[j] ?
				(sqa_root_s2[j] | (RTW'(1) << (RTW - 1 - j))) : sqa_root_s2[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_rem_s2[0]  <= {ss, {(RAW - SSW){1'b0}}};
			sqa_root_s2[0] <= '0;
			sqa_c_s2[0]    <= sqa_front;
			for (int j = 0; j < RTW; j++) begin
				sqa_rem_s2[j+1]  <= sqa_rem_nx[j];
				sqa_root_s2[j+1] <= sqa_root_nx[j];
				sqa_c_s2[j+1]    <= sqa_c_s2[j];
			end
		end
	end

	// normalizing divider, three lanes
	logic [DW-1:0]      mag [3];
	logic [DVW-1:0]     div_num [3];
	mid_t               div_front;
	logic [DVW-1:0]     div_rem_s3 [QW+1][3];
	logic [2:0][QW-1:0] div_q_s3 [QW+1];
	logic [RTW-1:0]     div_len_s3 [QW+1];
	mid_t               div_c_s3 [QW+1];
	logic [DVW-1:0]     div_sub [QW];
	logic               div_take [QW][3];
	logic [DVW-1:0]     div_rem_nx [QW][3];
	logic [2:0][QW-1:0] div_q_nx [QW];

	always_comb begin
		div_front.n    = sqa_c_s2[RTW].n;
		div_front.eta  = sqa_c_s2[RTW].eta;
		div_front.zero = sqa_c_s2[RTW].zero;
		for (int i = 0; i < 3; i++) begin
			div_front.sgn[i] = sqa_c_s2[RTW].d[i][DW-1];
			mag[i]     = sqa_c_s2[RTW].d[i][DW-1] ?
				DW'(-sqa_c_s2[RTW].d[i]) : sqa_c_s2[RTW].d[i];
			div_num[i] = (DVW'(mag[i]) << (FRAC_BITS + 8))
				+ DVW'(sqa_root_s2[RTW] >> 1);
		end
		for (int j = 0; j < QW; j++) begin
			div_sub[j]  = DVW'(div_len_s3[j]) << (QW - 1 - j);
			div_q_nx[j] = div_q_s3[j];
			for (int i = 0; i < 3; i++) begin
				div_take[j][i]   = div_rem_s3[j][i] >= div_sub[j];
				div_rem_nx[j][i] = div_take[j][i] ?
					(div_rem_s3[j][i] - div_sub[j]) : div_rem_s3[j][i];
				if (div_take[j][i]) begin
					div_q_nx[j][i][QW-1-j] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				div_rem_s3[0][i] <= div_num[i];
			end
			div_q_s3[0]   <= '0;
			div_len_s3[0] <= sqa_root_s2[RTW];
			div_c_s3[0]   <= div_front;
			for (int j = 0; j < QW; j++) begin
				for (int i = 0; i < 3; i++) begin
					div_rem_s3[j+1][i] <= div_rem_nx[j][i];
				end
				div_q_s3[j+1]   <= div_q_nx[j];
				div_len_s3[j+1] <= div_len_s3[j];
				div_c_s3[j+1]   <= div_c_s3[j];
			end
		end
	end

	// signed unit direction
	logic signed [UW-1:0] u_s4 [3];
	mid_t                 m_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				u_s4[i] <= div_c_s3[QW].sgn[i] ?
					-$signed({1'b0, div_q_s3[QW][i]}) : $signed({1'b0, div_q_s3[QW][i]});
			end
			m_s4 <= div_c_s3[QW];
		end
	end

	// dot products and eta terms
	logic signed [DW-1:0]  n4 [3];
	logic signed [DW:0]    eta4;
	logic signed [UNW-1:0] un_s5 [3];
	logic signed [EUW-1:0] eu_s5 [3];
	logic [EEW-1:0]        ee_s5;
	logic signed [UW-1:0]  u_s5 [3];
	mid_t                  m_s5;

	always_comb begin
		eta4 = $signed({1'b0, m_s4.eta});
		for (int i = 0; i < 3; i++) begin
			n4[i] = $signed(m_s4.n[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				un_s5[i] <= UNW'(u_s4[i]) * UNW'(n4[i]);
				eu_s5[i] <= EUW'(u_s4[i]) * EUW'(eta4);
				u_s5[i]  <= u_s4[i];
			end
			ee_s5 <= EEW'(m_s4.eta) * EEW'(m_s4.eta);
			m_s5  <= m_s4;
		end
	end

	// cosine and eta squared
	logic signed [CW-1:0]   c_s6;
	logic signed [E2W-1:0]  e2_s6;
	logic signed [EURW-1:0] eur_s6 [3];
	logic signed [UW-1:0]   u_s6 [3];
	mid_t                   m_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s6  <= CW'(rnd(64'(un_s5[0]) + 64'(un_s5[1]) + 64'(un_s5[2])));
			e2_s6 <= E2W'(rnd($signed(64'(ee_s5))));
			for (int i = 0; i < 3; i++) begin
				eur_s6[i] <= EURW'(rnd(64'(eu_s5[i])));
				u_s6[i]   <= u_s5[i];
			end
			m_s6 <= m_s5;
		end
	end

	// cosine products
	logic signed [CCW-1:0]  cc_s7;
	logic signed [CNW-1:0]  cn_s7 [3];
	logic signed [ECPW-1:0] ec_s7;
	logic signed [E2W-1:0]  e2_s7;
	logic signed [EURW-1:0] eur_s7 [3];
	logic signed [UW-1:0]   u_s7 [3];
	mid_t                   m_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s7 <= CCW'(c_s6) * CCW'(c_s6);
			ec_s7 <= ECPW'(c_s6) * ECPW'($signed({1'b0, m_s6.eta}));
			for (int i = 0; i < 3; i++) begin
				cn_s7[i]  <= CNW'(c_s6) * CNW'($signed(m_s6.n[i]));
				eur_s7[i] <= eur_s6[i];
				u_s7[i]   <= u_s6[i];
			end
			e2_s7 <= e2_s6;
			m_s7  <= m_s6;
		end
	end

	// one minus cosine squared, mirror and eta-cosine terms
	logic signed [OMW-1:0]  omc_s8;
	logic signed [CNRW-1:0] cnr_s8 [3];
	logic signed [ECW-1:0]  ecr_s8;
	logic signed [E2W-1:0]  e2_s8;
	logic signed [EURW-1:0] eur_s8 [3];
	logic signed [UW-1:0]   u_s8 [3];
	mid_t                   m_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			omc_s8 <= OMW'(ONE - rnd(64'(cc_s7)));
			ecr_s8 <= ECW'(rnd(64'(ec_s7)));
			for (int i = 0; i < 3; i++) begin
				cnr_s8[i] <= CNRW'(rnd(64'(cn_s7[i]) <<< 1));
				eur_s8[i] <= eur_s7[i];
				u_s8[i]   <= u_s7[i];
			end
			e2_s8 <= e2_s7;
			m_s8  <= m_s7;
		end
	end

	// eta squared times sine squared
	logic signed [EKW-1:0]  ek_s9;
	logic signed [CNRW-1:0] cnr_s9 [3];
	logic signed [ECW-1:0]  ecr_s9;
	logic signed [EURW-1:0] eur_s9 [3];
	logic signed [UW-1:0]   u_s9 [3];
	mid_t                   m_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			ek_s9  <= EKW'(e2_s8) * EKW'(omc_s8);
			ecr_s9 <= ecr_s8;
			for (int i = 0; i < 3; i++) begin
				cnr_s9[i] <= cnr_s8[i];
				eur_s9[i] <= eur_s8[i];
				u_s9[i]   <= u_s8[i];
			end
			m_s9 <= m_s8;
		end
	end

	// k, reflection decision and square root of k
	logic signed [63:0] kv;
	logic [KCW-1:0]     kc;
	fin_t               sqb_front;
	logic [RBW-1:0]     sqb_rem_s10 [SW+1];
	logic [SW-1:0]      sqb_root_s10 [SW+1];
	fin_t               sqb_c_s10 [SW+1];
	logic [RBW:0]       sqb_trial [SW];
	logic               sqb_take [SW];
	logic [RBW-1:0]     sqb_rem_nx [SW];
	logic [SW-1:0]      sqb_root_nx [SW];

	always_comb begin
		kv = ONE - rnd(64'(ek_s9));
		if (kv[63]) begin
			kc = '0;
		end else if (kv > KMAX) begin
			kc = KCW'(KMAX);
		end else begin
			kc = KCW'(kv);
		end
		for (int i = 0; i < 3; i++) begin
			sqb_front.u[i]   = u_s9[i];
			sqb_front.eur[i] = eur_s9[i];
			sqb_front.cnr[i] = cnr_s9[i];
		end
		sqb_front.ecr  = ecr_s9;
		sqb_front.n    = m_s9.n;
		sqb_front.tir  = kv[63];
		sqb_front.zero = m_s9.zero;
		for (int j = 0; j < SW; j++) begin
			sqb_trial[j]   = (RBW1'(sqb_root_s10[j]) << (SW - j))
				+ (RBW1'(1) << (2 * (SW - 1 - j)));
			sqb_take[j]    = RBW1'(sqb_rem_s10[j]) >= sqb_trial[j];
			sqb_rem_nx[j]  = sqb_take[j] ?
				RBW'(RBW1'(sqb_rem_s10[j]) - sqb_trial[j]) : sqb_rem_s10[j];
			sqb_root_nx[j] = sqb_take[j] ?
				(sqb_root_s10[j] | (SW'(1) << (SW - 1 - j))) : sqb_root_s10[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqb_rem_s10[0]  <= RBW'(kc) << FRAC_BITS;
			sqb_root_s10[0] <= '0;
			sqb_c_s10[0]    <= sqb_front;
			for (int j = 0; j < SW; j++) begin
				sqb_rem_s10[j+1]  <= sqb_rem_nx[j];
				sqb_root_s10[j+1] <= sqb_root_nx[j];
				sqb_c_s10[j+1]    <= sqb_c_s10[j];
			end
		end
	end

	// normal scale
	logic signed [GW-1:0] g_s11;
	fin_t                 f_s11;

	always_ff @(posedge clk) begin
		if (en) begin
			g_s11 <= GW'($signed(sqb_c_s10[SW].ecr))
				+ GW'($signed({1'b0, sqb_root_s10[SW]}));
			f_s11 <= sqb_c_s10[SW];
		end
	end

	logic signed [GNW-1:0] gn_s12 [3];
	fin_t                  f_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				gn_s12[i] <= GNW'(g_s11) * GNW'($signed(f_s11.n[i]));
			end
			f_s12 <= f_s11;
		end
	end

	// select, saturate, zero the result of zero-length words
	logic signed [FW-1:0] r [3];
	logic signed [DW-1:0] rs [3];
	vref_out_t            res_s13;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (f_s12.tir) begin
				r[i] = FW'($signed(f_s12.u[i])) - FW'($signed(f_s12.cnr[i]));
			end else begin
				r[i] = FW'($signed(f_s12.eur[i])) - FW'(rnd(64'(gn_s12[i])));
			end
			rs[i] = f_s12.zero ? '0 : sat16(r[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s13.out_x         <= rs[0];
			res_s13.out_y         <= rs[1];
			res_s13.out_z         <= rs[2];
			res_s13.total_reflect <= f_s12.tir & ~f_s12.zero;
		end
	end

	assign res = res_s13;

endmodule
